/* rtl/swcrc_pkg.sv */
// Package with shared types, constants and the CRC-16 byte update for the frame checker.
`timescale 1ns / 1ps
`default_nettype none

package swcrc_pkg;

	// Default frame store depth in bytes.
	localparam int STORE_DEPTH_DEF = 2048;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] SYNC_WORD_RST  = 16'hEB90;
	localparam logic [11:0] MIN_LENGTH_RST = 12'd4;
	localparam logic [11:0] MAX_LENGTH_RST = 12'd1996;

	// Header length values below this are always rejected.
	localparam logic [15:0] HDR_LEN_FLOOR = 16'd4;

	// CRC-16 parameters.
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Result kinds.
	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_GOOD    = 3'd1;
	localparam logic [2:0] KIND_CRC_ERR = 3'd2;
	localparam logic [2:0] KIND_LEN_ERR = 3'd3;
	localparam logic [2:0] KIND_OVERRUN = 3'd4;

	// Output queue sizing.
	localparam int Q_DEPTH = 3;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 2;

	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_HEADER,
		PH_BODY,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_in;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_out;
		logic        last;
		logic [7:0]  frame_count;
		logic [5:0]  fee_id;
		logic [15:0] frame_length;
		logic [31:0] event_number;
		logic [31:0] good_events;
	} out_t;

	// One byte of CRC-16, MSB first, no reflection.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/swcrc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module swcrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/swcrc_parser.sv */
// Frame parser: sync hunt, header capture, CRC check, store writes and drain reads.
`timescale 1ns / 1ps
`default_nettype none

module swcrc_parser #(
	parameter int STORE_DEPTH = swcrc_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_ready,
	input  wire swcrc_pkg::in_t                     in_data,
	input  wire logic                               cfg_valid,
	input  wire logic [swcrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [swcrc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                    ram_we,
	output logic      [$clog2(STORE_DEPTH)-1:0]     ram_waddr,
	output logic      [7:0]                         ram_wdata,
	output logic                                    ram_re,
	output logic      [$clog2(STORE_DEPTH)-1:0]     ram_raddr,
	output logic                                    res_valid_s1,
	output swcrc_pkg::out_t                         res_s1
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = 17;
	localparam logic [CW-1:0] MaxFrameLen = CW'(STORE_DEPTH + 2);

	swcrc_pkg::phase_t phase_q, phase_n;
	logic [1:0]    hdr_idx_q, hdr_idx_n;
	logic [7:0]    count_q, count_n;
	logic [5:0]    fee_q, fee_n;
	logic [15:0]   length_q, length_n;
	logic [15:0]   crc_q, crc_n;
	logic [AW:0]   body_q, body_n;
	logic [AW-1:0] drain_q, drain_n;
	logic [31:0]   event_q, event_n;
	logic [31:0]   good_q, good_n;
	logic [15:0]   sync_q;
	logic [11:0]   min_len_q;
	logic [11:0]   max_len_q;

	logic          acc;
	logic          is_byte;
	logic          is_tick;
	logic [7:0]    b;
	logic [15:0]   crc_upd;
	logic [15:0]   len_hdr;
	logic          len_bad;
	logic [AW:0]   body_inc;
	logic          body_done;
	logic [AW:0]   drain_inc;
	logic [15:0]   payload_len;
	logic          drain_last;
	logic          res_valid_n;
	logic [2:0]    res_kind_n;
	logic          res_last_n;

	assign acc     = in_valid && in_ready;
	assign b       = in_data.data_in;
	assign is_tick = acc && in_data.func;
	assign is_byte = acc && !in_data.func;

	assign crc_upd = swcrc_pkg::crc16_byte(crc_q, b);
	assign len_hdr = {length_q[15:8], b};
	assign len_bad = (len_hdr < swcrc_pkg::HDR_LEN_FLOOR) ||
			(len_hdr < {4'd0, min_len_q}) ||
			(len_hdr > {4'd0, max_len_q}) ||
			({1'b0, len_hdr} > MaxFrameLen);

	assign body_inc  = body_q + 1'b1;
	assign body_done = CW'(body_inc) >= ({1'b0, length_q} - CW'(2));

	assign drain_inc   = {1'b0, drain_q} + 1'b1;
	assign payload_len = length_q - swcrc_pkg::HDR_LEN_FLOOR;
	assign drain_last  = CW'(drain_inc) >= {1'b0, payload_len};

	// Next phase.
	always_comb begin
		phase_n = phase_q;
		if (is_tick) begin
			if (phase_q == swcrc_pkg::PH_DRAIN && drain_last) begin
				phase_n = swcrc_pkg::PH_HUNT1;
			end
		end else if (is_byte) begin
			case (phase_q)
				swcrc_pkg::PH_HUNT1: begin
					if (b == sync_q[15:8]) begin
						phase_n = swcrc_pkg::PH_HUNT2;
					end
				end
				swcrc_pkg::PH_HUNT2: begin
					phase_n = (b == sync_q[7:0]) ? swcrc_pkg::PH_HEADER : swcrc_pkg::PH_HUNT1;
				end
				swcrc_pkg::PH_HEADER: begin
					if (hdr_idx_q == 2'd3) begin
						phase_n = len_bad ? swcrc_pkg::PH_HUNT1 : swcrc_pkg::PH_BODY;
					end
				end
				swcrc_pkg::PH_BODY: begin
					if (body_done) begin
						if (crc_upd == 16'h0000 && length_q > swcrc_pkg::HDR_LEN_FLOOR) begin
							phase_n = swcrc_pkg::PH_DRAIN;
						end else begin
							phase_n = swcrc_pkg::PH_HUNT1;
						end
					end
				end
				swcrc_pkg::PH_DRAIN: begin
					phase_n = swcrc_pkg::PH_DRAIN;
				end
				default: begin
					phase_n = swcrc_pkg::PH_HUNT1;
				end
			endcase
		end
	end

	// Datapath updates, store accesses and result selection.
	always_comb begin
		hdr_idx_n   = hdr_idx_q;
		count_n     = count_q;
		fee_n       = fee_q;
		length_n    = length_q;
		crc_n       = crc_q;
		body_n      = body_q;
		drain_n     = drain_q;
		event_n     = event_q;
		good_n      = good_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		res_valid_n = 1'b0;
		res_kind_n  = swcrc_pkg::KIND_PAYLOAD;
		res_last_n  = 1'b0;
		if (is_tick) begin
			if (phase_q == swcrc_pkg::PH_DRAIN) begin
				ram_re      = 1'b1;
				res_valid_n = 1'b1;
				res_kind_n  = swcrc_pkg::KIND_PAYLOAD;
				res_last_n  = drain_last;
				drain_n     = drain_last ? '0 : drain_inc[AW-1:0];
			end
		end else if (is_byte) begin
			case (phase_q)
				swcrc_pkg::PH_HUNT2: begin
					if (b == sync_q[7:0]) begin
						if (event_q != 32'hFFFF_FFFF) begin
							event_n = event_q + 32'd1;
						end
						hdr_idx_n = 2'd0;
						crc_n     = swcrc_pkg::CRC_INIT;
					end
				end
				swcrc_pkg::PH_HEADER: begin
					crc_n = crc_upd;
					case (hdr_idx_q)
						2'd0: count_n = b;
						2'd1: fee_n = b[5:0];
						2'd2: length_n = {b, 8'h00};
						default: length_n = len_hdr;
					endcase
					hdr_idx_n = hdr_idx_q + 2'd1;
					if (hdr_idx_q == 2'd3) begin
						if (len_bad) begin
							res_valid_n = 1'b1;
							res_kind_n  = swcrc_pkg::KIND_LEN_ERR;
						end else begin
							body_n = '0;
						end
					end
				end
				swcrc_pkg::PH_BODY: begin
					crc_n  = crc_upd;
					ram_we = 1'b1;
					body_n = body_inc;
					if (body_done) begin
						body_n      = '0;
						res_valid_n = 1'b1;
						if (crc_upd != 16'h0000) begin
							res_kind_n = swcrc_pkg::KIND_CRC_ERR;
						end else begin
							res_kind_n = swcrc_pkg::KIND_GOOD;
							drain_n    = '0;
							if (good_q != 32'hFFFF_FFFF) begin
								good_n = good_q + 32'd1;
							end
						end
					end
				end
				swcrc_pkg::PH_DRAIN: begin
					res_valid_n = 1'b1;
					res_kind_n  = swcrc_pkg::KIND_OVERRUN;
				end
				default: begin
				end
			endcase
		end
	end

	assign ram_waddr = body_q[AW-1:0];
	assign ram_wdata = b;
	assign ram_raddr = drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= swcrc_pkg::PH_HUNT1;
			hdr_idx_q <= '0;
			count_q   <= '0;
			fee_q     <= '0;
			length_q  <= '0;
			crc_q     <= swcrc_pkg::CRC_INIT;
			body_q    <= '0;
			drain_q   <= '0;
			event_q   <= '0;
			good_q    <= '0;
			sync_q    <= swcrc_pkg::SYNC_WORD_RST;
			min_len_q <= swcrc_pkg::MIN_LENGTH_RST;
			max_len_q <= swcrc_pkg::MAX_LENGTH_RST;
			res_valid_s1 <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			hdr_idx_q <= hdr_idx_n;
			count_q   <= count_n;
			fee_q     <= fee_n;
			length_q  <= length_n;
			crc_q     <= crc_n;
			body_q    <= body_n;
			drain_q   <= drain_n;
			event_q   <= event_n;
			good_q    <= good_n;
			res_valid_s1 <= res_valid_n;
			if (cfg_valid) begin
				case (cfg_index)
					swcrc_pkg::CFG_SYNC_WORD:  sync_q <= cfg_data;
					swcrc_pkg::CFG_MIN_LENGTH: min_len_q <= cfg_data[11:0];
					swcrc_pkg::CFG_MAX_LENGTH: max_len_q <= cfg_data[11:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Result fields carry the header and counter values as they stand after this item.
	always_ff @(posedge clk) begin
		res_s1.kind         <= res_kind_n;
		res_s1.data_out     <= 8'h00;
		res_s1.last         <= res_last_n;
		res_s1.frame_count  <= count_n;
		res_s1.fee_id       <= fee_n;
		res_s1.frame_length <= length_n;
		res_s1.event_number <= event_n;
		res_s1.good_events  <= good_n;
	end

	// The store is written only while collecting a body and read only while draining.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read in the same cycle");

	// A drained frame always has a payload that fits in the store.
	a_drain_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == swcrc_pkg::PH_DRAIN) |->
			(length_q > swcrc_pkg::HDR_LEN_FLOOR) && ({1'b0, length_q} <= MaxFrameLen))
		else $error("draining with an invalid frame length");

	// The body index never runs past the stored length.
	a_body_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == swcrc_pkg::PH_BODY) |-> (CW'(body_q) < ({1'b0, length_q} - CW'(2))))
		else $error("body index beyond frame length");

endmodule

`default_nettype wire

/* rtl/swcrc_outq.sv */
// Output queue that merges store read data into results and buffers them for the receiver.
`timescale 1ns / 1ps
`default_nettype none

module swcrc_outq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire swcrc_pkg::out_t  push_item,
	input  wire logic [7:0]       rdata,
	output logic                  room,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output swcrc_pkg::out_t       out_data
);

	swcrc_pkg::out_t                entry_q [swcrc_pkg::Q_DEPTH];
	logic [swcrc_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [swcrc_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [swcrc_pkg::Q_CNT_W-1:0]  count_q;
	logic                           pop;
	swcrc_pkg::out_t                item;
	logic [swcrc_pkg::Q_CNT_W:0]    level;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_ptr_q];

	// A result still in the first stage will land here next cycle, so it counts as taken.
	assign level = {1'b0, count_q} + {{swcrc_pkg::Q_CNT_W{1'b0}}, push};
	assign room  = level < (swcrc_pkg::Q_CNT_W + 1)'(swcrc_pkg::Q_DEPTH);

	always_comb begin
		item = push_item;
		item.data_out = (push_item.kind == swcrc_pkg::KIND_PAYLOAD) ? rdata : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == swcrc_pkg::Q_PTR_W'(swcrc_pkg::Q_DEPTH - 1)) ?
						'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == swcrc_pkg::Q_PTR_W'(swcrc_pkg::Q_DEPTH - 1)) ?
						'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (swcrc_pkg::Q_CNT_W + 1)'(swcrc_pkg::Q_DEPTH))
		else $error("output queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> ({1'b0, count_q} < (swcrc_pkg::Q_CNT_W + 1)'(swcrc_pkg::Q_DEPTH)))
		else $error("result pushed into a full output queue");

endmodule

`default_nettype wire

/* rtl/sync_word_crc16_frame_checker.sv */
// Top level of the sync-word frame checker with CRC-16 and payload drain.
//
// Input channel (in_valid/in_ready/in_data): one transaction per byte or drain tick.
// With func low, data_in is a received byte fed to the sync hunt, header capture
// and body collection with a CRC-16 (0x1021, init 0xFFFF) running over header and
// body. With func high, the transaction is a tick that hands out one stored payload
// byte of the last good frame; a tick with nothing to drain gives no result.
// Output channel (out_valid/out_ready/out_data): at most one result per input
// transaction, in order: payload byte, frame good, CRC error, length error, overrun.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// the user must write it only while the block is idle; the block does not enforce this.
// Throughput is one input transaction per cycle while in_ready is high, set by the
// combinational CRC byte update and the separate write and read ports of the frame
// store RAM. A result passes the parser stage register, together with the RAM read,
// and then an output queue entry on its way to the output.
// When the receiver stalls, a three-entry output queue absorbs results in flight and
// in_ready drops once it would fill; nothing is lost or repeated.
// Reset clears all control state and the registers return to their defaults at once;
// the frame store needs no clearing pass since only bytes of the current frame are read.
`timescale 1ns / 1ps
`default_nettype none

module sync_word_crc16_frame_checker #(
	parameter int STORE_DEPTH = swcrc_pkg::STORE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire swcrc_pkg::in_t                   in_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output swcrc_pkg::out_t                       out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [swcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swcrc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [7:0]      ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;
	logic            res_valid_s1;
	swcrc_pkg::out_t res_s1;
	logic            room;

	// Registers are plain flops, so a configuration write always completes at once.
	assign cfg_ready = 1'b1;

	// Accept whenever the output queue can still hold every result in flight.
	assign in_ready = room;

	swcrc_parser #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1)
	);

	// Frame store: body bytes are written as they arrive and read back while draining.
	swcrc_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The registered read data lines up with the first-stage result in the cycle after the read.
	swcrc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid_s1),
		.push_item (res_s1),
		.rdata     (ram_rdata),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* tb/sync_word_crc16_frame_checker_tb.sv */
// Self-checking testbench for the sync-word CRC-16 frame checker with payload drain.
`timescale 1ns / 1ps

module sync_word_crc16_frame_checker_tb;

	localparam int FRAME_STORE_BYTES = swcrc_pkg::STORE_DEPTH_DEF;
	// Cycles without any accepted transaction before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Settling time after the last result, covering the parser stage and the output queue.
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_REPORTS = 10;

	// The scoreboard carries its own model of the parser: hunt, header capture,
	// body collection with a running CRC, and the drain of a good frame. Every
	// accepted input transaction advances the model and may queue one result.
	class frame_checker_scoreboard;
		logic [15:0]       sync_word;
		logic [11:0]       min_len;
		logic [11:0]       max_len;
		swcrc_pkg::phase_t phase;
		int unsigned       hdr_idx;
		logic [7:0]        count_q;
		logic [5:0]        fee_q;
		logic [15:0]       len_q;
		logic [15:0]       crc;
		int unsigned       body_idx;
		logic [7:0]        store [FRAME_STORE_BYTES];
		int unsigned       drain_idx;
		logic [31:0]       events;
		logic [31:0]       good_frames;
		swcrc_pkg::out_t   expected_results[$];
		int unsigned       fail_count;

		function new();
			sync_word   = swcrc_pkg::SYNC_WORD_RST;
			min_len     = swcrc_pkg::MIN_LENGTH_RST;
			max_len     = swcrc_pkg::MAX_LENGTH_RST;
			phase       = swcrc_pkg::PH_HUNT1;
			hdr_idx     = 0;
			count_q     = '0;
			fee_q       = '0;
			len_q       = '0;
			crc         = swcrc_pkg::CRC_INIT;
			body_idx    = 0;
			drain_idx   = 0;
			events      = '0;
			good_frames = '0;
			fail_count  = 0;
		endfunction

		// Bit-serial form of the CCITT polynomial, MSB first, no final xor.
		static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c = {c[14:0], 1'b0};
				if (fb) begin
					c = c ^ swcrc_pkg::CRC_POLY;
				end
			end
			return c;
		endfunction

		function void write_reg(logic [swcrc_pkg::CFG_IDX_W-1:0] idx,
				logic [swcrc_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				swcrc_pkg::CFG_SYNC_WORD: begin
					sync_word = data;
				end
				swcrc_pkg::CFG_MIN_LENGTH: begin
					min_len = data[11:0];
				end
				swcrc_pkg::CFG_MAX_LENGTH: begin
					max_len = data[11:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void push_result(logic [2:0] kind, logic [7:0] data, logic last);
			swcrc_pkg::out_t r;
			r.kind         = kind;
			r.data_out     = data;
			r.last         = last;
			r.frame_count  = count_q;
			r.fee_id       = fee_q;
			r.frame_length = len_q;
			r.event_number = events;
			r.good_events  = good_frames;
			expected_results.push_back(r);
		endfunction

		function void predict_item(swcrc_pkg::in_t it);
			logic [7:0] b;
			logic       last;
			b = it.data_in;
			if (it.func) begin
				// A tick outside the drain is silently ignored.
				if (phase != swcrc_pkg::PH_DRAIN) begin
					return;
				end
				last = (drain_idx + 1 >= int'(len_q) - 4);
				push_result(swcrc_pkg::KIND_PAYLOAD, store[drain_idx], last);
				drain_idx++;
				if (last) begin
					phase = swcrc_pkg::PH_HUNT1;
					drain_idx = 0;
				end
				return;
			end
			case (phase)
				swcrc_pkg::PH_HUNT1: begin
					if (b == sync_word[15:8]) begin
						phase = swcrc_pkg::PH_HUNT2;
					end
				end
				swcrc_pkg::PH_HUNT2: begin
					// The second byte is consumed either way.
					if (b == sync_word[7:0]) begin
						if (events != '1) begin
							events++;
						end
						hdr_idx = 0;
						crc = swcrc_pkg::CRC_INIT;
						phase = swcrc_pkg::PH_HEADER;
					end else begin
						phase = swcrc_pkg::PH_HUNT1;
					end
				end
				swcrc_pkg::PH_HEADER: begin
					crc = crc_next(crc, b);
					if (hdr_idx == 0) begin
						count_q = b;
					end else if (hdr_idx == 1) begin
						fee_q = b[5:0];
					end else if (hdr_idx == 2) begin
						len_q = {b, 8'h00};
					end else begin
						len_q[7:0] = b;
					end
					if (hdr_idx < 3) begin
						hdr_idx++;
					end else begin
						hdr_idx = 0;
						if (len_q < swcrc_pkg::HDR_LEN_FLOOR || len_q < min_len ||
								len_q > max_len ||
								int'(len_q) > FRAME_STORE_BYTES + 2) begin
							phase = swcrc_pkg::PH_HUNT1;
							push_result(swcrc_pkg::KIND_LEN_ERR, 8'h00, 1'b0);
						end else begin
							body_idx = 0;
							phase = swcrc_pkg::PH_BODY;
						end
					end
				end
				swcrc_pkg::PH_BODY: begin
					crc = crc_next(crc, b);
					if (body_idx < FRAME_STORE_BYTES) begin
						store[body_idx] = b;
					end
					body_idx++;
					if (body_idx >= int'(len_q) - 2) begin
						body_idx = 0;
						if (crc != 16'h0000) begin
							phase = swcrc_pkg::PH_HUNT1;
							push_result(swcrc_pkg::KIND_CRC_ERR, 8'h00, 1'b0);
						end else begin
							if (good_frames != '1) begin
								good_frames++;
							end
							drain_idx = 0;
							phase = (len_q > 16'd4) ? swcrc_pkg::PH_DRAIN : swcrc_pkg::PH_HUNT1;
							push_result(swcrc_pkg::KIND_GOOD, 8'h00, 1'b0);
						end
					end
				end
				swcrc_pkg::PH_DRAIN: begin
					push_result(swcrc_pkg::KIND_OVERRUN, 8'h00, 1'b0);
				end
				default: begin
					phase = swcrc_pkg::PH_HUNT1;
				end
			endcase
		endfunction

		function string show(swcrc_pkg::out_t r);
			return $sformatf("kind=%0d data=%02h last=%0b cnt=%02h fee=%02h len=%04h evt=%0d good=%0d",
				r.kind, r.data_out, r.last, r.frame_count, r.fee_id, r.frame_length,
				r.event_number, r.good_events);
		endfunction

		function void check_result(swcrc_pkg::out_t got);
			swcrc_pkg::out_t want;
			string           diffs;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("ERROR: result with nothing expected: %s", show(got));
				end
				return;
			end
			want = expected_results.pop_front();
			diffs = "";
			if (got.kind !== want.kind) diffs = {diffs, " kind"};
			if (got.data_out !== want.data_out) diffs = {diffs, " data_out"};
			if (got.last !== want.last) diffs = {diffs, " last"};
			if (got.frame_count !== want.frame_count) diffs = {diffs, " frame_count"};
			if (got.fee_id !== want.fee_id) diffs = {diffs, " fee_id"};
			if (got.frame_length !== want.frame_length) diffs = {diffs, " frame_length"};
			if (got.event_number !== want.event_number) diffs = {diffs, " event_number"};
			if (got.good_events !== want.good_events) diffs = {diffs, " good_events"};
			if (diffs != "") begin
				fail_count++;
				if (fail_count <= MAX_REPORTS) begin
					$display("ERROR: mismatch in%s", diffs);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	swcrc_pkg::in_t                  in_data = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	swcrc_pkg::out_t                 out_data;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [swcrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [swcrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	frame_checker_scoreboard sb;
	// While quiet is set, neither side inserts any idle cycles.
	bit          quiet = 1'b0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;

	sync_word_crc16_frame_checker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// The receiver stalls with a probability of roughly nine percent, except while quiet.
	always @(negedge clk) begin
		out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
	end

	// Monitor: all handshakes are sampled at the rising edge. A result that is
	// accepted in the same cycle as an input belongs to an earlier input, so
	// the result is checked before the new input advances the model. The same
	// block runs the watchdog on cycles where no transaction of any kind moves.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_result(out_data);
		end
		if (in_valid && in_ready) begin
			sb.predict_item(in_data);
		end
		if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Presents one input transaction. It is entered just after a falling edge
	// and returns just after the falling edge that follows acceptance, with
	// in_valid still high so that back-to-back items need no extra cycle.
	task automatic send_item(input logic is_tick, input logic [7:0] value);
		items_sent++;
		if (!quiet) begin
			while ($urandom_range(99) < 9) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		in_data.func = is_tick;
		in_data.data_in = value;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Register writes only go out once every expected result has arrived and
	// the pipeline has had time to settle.
	task automatic write_config(input logic [swcrc_pkg::CFG_IDX_W-1:0] idx,
			input logic [swcrc_pkg::CFG_DATA_W-1:0] data);
		in_valid = 1'b0;
		while (sb.expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_settings(input logic [15:0] sync, input logic [11:0] lo,
			input logic [11:0] hi);
		write_config(swcrc_pkg::CFG_SYNC_WORD, sync);
		write_config(swcrc_pkg::CFG_MIN_LENGTH, {4'h0, lo});
		write_config(swcrc_pkg::CFG_MAX_LENGTH, {4'h0, hi});
	endtask

	// Sends the marker and header, and, if the model shows that the length was
	// accepted, a body whose trailing two bytes close the CRC to zero. A
	// corrupted frame has one bit flipped somewhere in its body; a truncated
	// one stops partway so that the following bytes get absorbed into it.
	task automatic run_frame(input logic [15:0] length, input logic [7:0] count,
			input logic [7:0] fee_byte, input bit corrupt, input bit truncate);
		logic [7:0]  body[$];
		logic [15:0] c;
		int          n;
		int          k;
		send_item(1'b0, sb.sync_word[15:8]);
		send_item(1'b0, sb.sync_word[7:0]);
		send_item(1'b0, count);
		send_item(1'b0, fee_byte);
		send_item(1'b0, length[15:8]);
		send_item(1'b0, length[7:0]);
		if (sb.phase != swcrc_pkg::PH_BODY) begin
			return;
		end
		c = sb.crc;
		for (k = 0; k < int'(length) - 4; k++) begin
			body.push_back(8'($urandom_range(255)));
			c = frame_checker_scoreboard::crc_next(c, body[k]);
		end
		body.push_back(c[15:8]);
		body.push_back(c[7:0]);
		if (corrupt) begin
			k = $urandom_range(body.size() - 1);
			body[k] = body[k] ^ (8'h01 << $urandom_range(7));
		end
		n = truncate ? $urandom_range(body.size() - 1) : body.size();
		for (k = 0; k < n; k++) begin
			send_item(1'b0, body[k]);
		end
	endtask

	// Ticks out the payload of a good frame; some received bytes are mixed in
	// to provoke overruns without breaking off the drain.
	task automatic drain_payload(input int overrun_pct);
		while (sb.phase == swcrc_pkg::PH_DRAIN) begin
			if ($urandom_range(99) < overrun_pct) begin
				send_item(1'b0, 8'($urandom_range(255)));
			end else begin
				send_item(1'b1, 8'($urandom_range(255)));
			end
		end
	endtask

	// Brings the parser back to hunting for the first marker byte.
	task automatic return_to_hunt();
		while (sb.phase != swcrc_pkg::PH_HUNT1) begin
			if (sb.phase == swcrc_pkg::PH_DRAIN) begin
				send_item(1'b1, 8'($urandom_range(255)));
			end else if (sb.phase == swcrc_pkg::PH_HUNT2) begin
				send_item(1'b0, ~sb.sync_word[7:0]);
			end else begin
				send_item(1'b0, 8'($urandom_range(255)));
			end
		end
	endtask

	// Mostly lengths inside the current bounds and kept short; the rest probe
	// just outside each bound, below the fixed floor, or anywhere at all.
	function automatic logic [15:0] pick_length();
		int lo;
		int hi;
		lo = (int'(sb.min_len) > 4) ? int'(sb.min_len) : 4;
		hi = int'(sb.max_len);
		if (hi > lo + 40) begin
			hi = lo + 40;
		end
		if ($urandom_range(99) < 80 && lo <= hi) begin
			return 16'($urandom_range(hi, lo));
		end
		case ($urandom_range(4))
			0: return 16'($urandom_range(3));
			1: return 16'(sb.min_len) - 16'd1;
			2: return 16'(sb.max_len) + 16'd1;
			3: return 16'($urandom_range(65535));
			default: return 16'hFFFF;
		endcase
	endfunction

	// Random traffic: mostly well-formed frames with random content, plus
	// corrupted and truncated frames, stray marker bytes, ticks and noise.
	task automatic run_traffic(input int unsigned budget);
		int unsigned stop_at;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 75) begin
				if ($urandom_range(9) != 0) begin
					return_to_hunt();
				end
				run_frame(pick_length(), 8'($urandom_range(255)), 8'($urandom_range(255)),
					$urandom_range(99) < 15, $urandom_range(99) < 5);
				drain_payload(8);
			end else begin
				repeat ($urandom_range(8, 1)) begin
					case ($urandom_range(3))
						0: send_item(1'b1, 8'($urandom_range(255)));
						1: send_item(1'b0, sb.sync_word[15:8]);
						default: send_item(1'b0, 8'($urandom_range(255)));
					endcase
				end
			end
		end
	endtask

	initial begin
		logic [7:0] rep;
		logic [11:0] lo;
		sb = new();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with the registers at their reset values.
		// A failed second marker byte is consumed and not taken as a new first byte.
		send_item(1'b0, swcrc_pkg::SYNC_WORD_RST[15:8]);
		send_item(1'b0, swcrc_pkg::SYNC_WORD_RST[15:8]);
		send_item(1'b0, swcrc_pkg::SYNC_WORD_RST[7:0]);
		// Largest possible length value is a length error; fee byte has all bits set.
		run_frame(16'hFFFF, 8'h00, 8'hFF, 1'b0, 1'b0);
		// Length four: frame good with an empty payload, hunting resumes at once.
		run_frame(16'd4, 8'hFF, 8'h40, 1'b0, 1'b0);
		// A tick with nothing to drain gives no result.
		send_item(1'b1, 8'hFF);
		// Two payload bytes; a byte that arrives during the drain is an overrun.
		run_frame(16'd6, 8'h5A, 8'h3F, 1'b0, 1'b0);
		send_item(1'b0, 8'h00);
		drain_payload(0);

		// Random part. The first stretch runs with no idling on either side.
		quiet = 1'b1;
		run_traffic(130);
		quiet = 1'b0;
		run_traffic(130);

		// Lengths from the floor of four up to 2048.
		apply_settings(16'($urandom_range(65535)), 12'd4, 12'd2048);
		return_to_hunt();
		run_traffic(180);

		// Crossed bounds at both extremes: every length is rejected.
		apply_settings(16'h0000, 12'd2048, 12'd4);
		run_traffic(100);

		apply_settings(16'hFFFF, 12'd10, 12'd40);
		run_traffic(180);

		// Marker with equal bytes, and only empty-payload frames accepted.
		rep = 8'($urandom_range(255));
		apply_settings({rep, rep}, 12'd4, 12'd4);
		run_traffic(130);

		lo = 12'($urandom_range(30, 4));
		apply_settings(16'($urandom_range(65535)), lo, lo + 12'($urandom_range(60)));
		run_traffic(220);

		// Let every outstanding result arrive, then watch a little longer for strays.
		in_valid = 1'b0;
		while (sb.expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES + 4) @(negedge clk);
		if (sb.fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/swcrc_pkg.sv
rtl/swcrc_ram.sv
rtl/swcrc_parser.sv
rtl/swcrc_outq.sv
rtl/sync_word_crc16_frame_checker.sv
tb/sync_word_crc16_frame_checker_tb.sv
